// ----- rtl/core/mcds_pkg.sv -----
// Shared types and constants for the input debounce and ADC scaler block.
// Used by every module under rtl/core; depends on nothing.
`timescale 1ns / 1ps

package mcds_pkg;

  // Digital channels, bit order: dimm, brake, hbrake, mode, up, down
  localparam int NCH       = 6;
  localparam int UP_BIT    = 4;
  localparam int DOWN_BIT  = 5;
  localparam int TIMER_W   = 8;
  localparam logic [TIMER_W-1:0] LIMIT_RESET = 8'd10;

  // Result field widths
  localparam int BATT_W = 15;
  localparam int COILV_W = 15;
  localparam int COILI_W = 14;
  localparam int POT_W  = 13;

  // Scale constants
  localparam int MUL_VOLT = 20;
  localparam int MUL_CURR = 10;
  localparam int MUL_POT  = 64;

  // Request codes
  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_CLEAR  = 1'b1
  } req_type_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_ACTIVE_LEVELS = 3'd0,
    REG_ANALOG_MODE   = 3'd1,
    REG_LIMIT_DIMM    = 3'd2,
    REG_LIMIT_BRAKE   = 3'd3,
    REG_LIMIT_HBRAKE  = 3'd4,
    REG_LIMIT_MODE    = 3'd5,
    REG_LIMIT_UP      = 3'd6,
    REG_LIMIT_DOWN    = 3'd7
  } reg_idx_t;

  // Per-lane strobes for one accepted word
  typedef struct packed {
    logic sample;
    logic clear_sel;
  } lane_ctrl_t;

  // Per-lane debounce status after the word
  typedef struct packed {
    logic state;
    logic flag;
  } lane_stat_t;

  // One result word
  typedef struct packed {
    logic [NCH-1:0]     states;
    logic [NCH-1:0]     change_flags;
    logic [BATT_W-1:0]  battery_mv;
    logic [COILV_W-1:0] coil_mv;
    logic [COILI_W-1:0] coil_ma;
    logic [POT_W-1:0]   pot_mv;
    logic [POT_W-1:0]   up_sw_mv;
    logic [POT_W-1:0]   down_sw_mv;
  } result_t;

endpackage

// ----- rtl/core/mcds_deb_lane.sv -----
// One debounce lane: tick timer, debounced state and sticky change flag.
// Depends on mcds_pkg.
`timescale 1ns / 1ps

module mcds_deb_lane
  import mcds_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  lane_ctrl_t         ctrl,
  input  logic               level,
  input  logic               active_level,
  input  logic [TIMER_W-1:0] limit,
  output lane_stat_t         stat_next
);

  logic [TIMER_W-1:0] timer;
  logic [TIMER_W-1:0] timer_next;
  logic               state;
  logic               flag;
  logic               mismatch;

  // Active when the pin's match with the configured level differs from the state
  assign mismatch = (level == active_level) != state;

  // Count disagreeing ticks, flip once the limit is passed; a clear drops the flag
  always_comb begin
    timer_next     = timer;
    stat_next.state = state;
    stat_next.flag  = flag;
    if (ctrl.sample) begin
      if (mismatch) begin
        if (timer >= limit) begin
          stat_next.state = ~state;
          stat_next.flag  = 1'b1;
          timer_next      = '0;
        end else begin
          timer_next = timer + 1'b1;
        end
      end else begin
        timer_next = '0;
      end
    end
    if (ctrl.clear_sel) begin
      stat_next.flag = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timer <= '0;
      state <= 1'b0;
      flag  <= 1'b0;
    end else begin
      timer <= timer_next;
      state <= stat_next.state;
      flag  <= stat_next.flag;
    end
  end

endmodule

// ----- rtl/core/mcds_scale_lane.sv -----
// One ADC scaling lane: constant multiply, optional divide by 13 through a
// reciprocal multiply, and the held value for clear words. Depends on mcds_pkg.
`timescale 1ns / 1ps

module mcds_scale_lane
  import mcds_pkg::*;
#(
  parameter int ADC_BITS = 10,
  parameter int MUL      = 20,
  parameter bit DIV13    = 1'b0,
  parameter int OUT_W    = 15
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample,
  input  logic [ADC_BITS-1:0] raw,
  output logic [OUT_W-1:0]    value_next
);

  localparam int PW = ADC_BITS + 7;

  logic [OUT_W-1:0] scaled;
  logic [OUT_W-1:0] calc;

  generate
    if (DIV13) begin : g_div
      // floor(x/13) = (x * ceil(2^K/13)) >> K, exact for x below 2^(K-4)
      localparam int XW = ADC_BITS + 6;
      localparam int K  = XW + 4;
      localparam int MW = K - 2;
      localparam logic [MW-1:0] RECIP = MW'((2**K + 12) / 13);
      logic [XW-1:0]    x;
      logic [XW+MW-1:0] prod;
      assign x    = {raw, 6'b0};
      assign prod = (XW+MW)'(x) * (XW+MW)'(RECIP);
      assign calc = prod[K+OUT_W-1:K];
    end else begin : g_mul
      logic [PW-1:0] prod;
      assign prod = PW'(raw) * PW'(MUL);
      assign calc = prod[OUT_W-1:0];
    end
  endgenerate

  // Take the new product on a sample, else repeat the held one
  assign value_next = sample ? calc : scaled;

  always_ff @(posedge clk) begin
    if (rst) begin
      scaled <= '0;
    end else if (sample) begin
      scaled <= calc;
    end
  end

endmodule

// ----- rtl/core/mcds_merge.sv -----
// Merging stage: takes the collected lane result word and holds it in an
// output register with a skid register behind it. Depends on mcds_pkg.
`timescale 1ns / 1ps

module mcds_merge
  import mcds_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  result_t    push_word,
  output logic       push_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    out_word
);

  logic    skid_valid;
  result_t skid_word;

  assign push_ready = ~skid_valid;

  // Advance skid into output, or park a word while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!push) begin
        out_valid <= 1'b0;
      end
    end else if (!out_valid) begin
      if (push) begin
        out_valid <= 1'b1;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload moves follow the same decisions
  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else if (push) begin
        out_word <= push_word;
      end
    end else if (!out_valid) begin
      if (push) begin
        out_word <= push_word;
      end
    end else if (push) begin
      skid_word <= push_word;
    end
  end

endmodule

// ----- rtl/core/multi_channel_input_debounce_scaler.sv -----
// Six-input debouncer with six ADC scaling lanes and an APB register port.
// Depends on mcds_pkg, mcds_deb_lane, mcds_scale_lane and mcds_merge.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one word per tick. req_type
//   sample debounces pin_levels and scales the six raw codes; req_type clear
//   drops the change flags selected by clear_mask and repeats the last
//   scaled values. Every word yields exactly one result word on the output
//   channel (out_valid/out_ready).
//   Results are registered. Throughput is one word per cycle unless the
//   receiver stalls; all six lanes and the reciprocal multipliers finish
//   in the accepting cycle, so the output register sets the pace.
//   When the receiver stalls, one more word is parked in a skid register;
//   in_ready drops only while that register is full.
//   Reset (rst, synchronous) clears timers, states, flags, held scaled
//   values and the output stage, and loads registers with their defaults
//   (active levels 0, analog mode off, all tick limits 10).
//   Registers are written only while idle: a rule for the user, not enforced.
`timescale 1ns / 1ps

module multi_channel_input_debounce_scaler
  import mcds_pkg::*;
#(
  parameter int ADC_BITS = 10
) (
  input  logic                clk,
  input  logic                rst,
  // APB register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // Input words
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                req_type,
  input  logic [NCH-1:0]      pin_levels,
  input  logic [NCH-1:0]      clear_mask,
  input  logic [ADC_BITS-1:0] raw_battery,
  input  logic [ADC_BITS-1:0] raw_coil_volt,
  input  logic [ADC_BITS-1:0] raw_coil_curr,
  input  logic [ADC_BITS-1:0] raw_pot,
  input  logic [ADC_BITS-1:0] raw_up_sw,
  input  logic [ADC_BITS-1:0] raw_down_sw,
  // Result words
  output logic                out_valid,
  input  logic                out_ready,
  output logic [NCH-1:0]      states,
  output logic [NCH-1:0]      change_flags,
  output logic [BATT_W-1:0]   battery_mv,
  output logic [COILV_W-1:0]  coil_mv,
  output logic [COILI_W-1:0]  coil_ma,
  output logic [POT_W-1:0]    pot_mv,
  output logic [POT_W-1:0]    up_sw_mv,
  output logic [POT_W-1:0]    down_sw_mv
);

  logic [NCH-1:0]     active_levels;
  logic [1:0]         analog_mode_mask;
  logic [TIMER_W-1:0] limits [NCH];

  reg_idx_t   reg_idx;
  logic       cfg_write;
  logic       accept;
  logic       is_sample;
  logic       is_clear;
  logic [NCH-1:0] analog_skip;
  lane_ctrl_t ctrl [NCH];
  lane_stat_t stat [NCH];
  result_t    word_next;
  result_t    out_word;

  // Register port
  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[4:2]);
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_levels    <= '0;
      analog_mode_mask <= '0;
      for (int i = 0; i < NCH; i++) begin
        limits[i] <= LIMIT_RESET;
      end
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_ACTIVE_LEVELS: active_levels    <= pwdata[NCH-1:0];
        REG_ANALOG_MODE:   analog_mode_mask <= pwdata[1:0];
        REG_LIMIT_DIMM:    limits[0]        <= pwdata[TIMER_W-1:0];
        REG_LIMIT_BRAKE:   limits[1]        <= pwdata[TIMER_W-1:0];
        REG_LIMIT_HBRAKE:  limits[2]        <= pwdata[TIMER_W-1:0];
        REG_LIMIT_MODE:    limits[3]        <= pwdata[TIMER_W-1:0];
        REG_LIMIT_UP:      limits[4]        <= pwdata[TIMER_W-1:0];
        REG_LIMIT_DOWN:    limits[5]        <= pwdata[TIMER_W-1:0];
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_ACTIVE_LEVELS: prdata = 32'(active_levels);
      REG_ANALOG_MODE:   prdata = 32'(analog_mode_mask);
      REG_LIMIT_DIMM:    prdata = 32'(limits[0]);
      REG_LIMIT_BRAKE:   prdata = 32'(limits[1]);
      REG_LIMIT_HBRAKE:  prdata = 32'(limits[2]);
      REG_LIMIT_MODE:    prdata = 32'(limits[3]);
      REG_LIMIT_UP:      prdata = 32'(limits[4]);
      REG_LIMIT_DOWN:    prdata = 32'(limits[5]);
    endcase
  end

  // Decode the accepted word into lane strobes
  assign accept    = in_valid & in_ready;
  assign is_sample = accept & (req_type_t'(req_type) == REQ_SAMPLE);
  assign is_clear  = accept & (req_type_t'(req_type) == REQ_CLEAR);

  always_comb begin
    analog_skip           = '0;
    analog_skip[UP_BIT]   = analog_mode_mask[0];
    analog_skip[DOWN_BIT] = analog_mode_mask[1];
  end

  // Debounce lanes
  for (genvar ch = 0; ch < NCH; ch++) begin : g_deb
    assign ctrl[ch].sample    = is_sample & ~analog_skip[ch];
    assign ctrl[ch].clear_sel = is_clear & clear_mask[ch];

    mcds_deb_lane u_lane (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl[ch]),
      .level        (pin_levels[ch]),
      .active_level (active_levels[ch]),
      .limit        (limits[ch]),
      .stat_next    (stat[ch])
    );

    assign word_next.states[ch]       = stat[ch].state;
    assign word_next.change_flags[ch] = stat[ch].flag;
  end

  // Scaling lanes
  mcds_scale_lane #(
    .ADC_BITS (ADC_BITS), .MUL (MUL_VOLT), .DIV13 (1'b0), .OUT_W (BATT_W)
  ) u_batt (
    .clk (clk), .rst (rst), .sample (is_sample),
    .raw (raw_battery), .value_next (word_next.battery_mv)
  );

  mcds_scale_lane #(
    .ADC_BITS (ADC_BITS), .MUL (MUL_VOLT), .DIV13 (1'b0), .OUT_W (COILV_W)
  ) u_coilv (
    .clk (clk), .rst (rst), .sample (is_sample),
    .raw (raw_coil_volt), .value_next (word_next.coil_mv)
  );

  mcds_scale_lane #(
    .ADC_BITS (ADC_BITS), .MUL (MUL_CURR), .DIV13 (1'b0), .OUT_W (COILI_W)
  ) u_coili (
    .clk (clk), .rst (rst), .sample (is_sample),
    .raw (raw_coil_curr), .value_next (word_next.coil_ma)
  );

  mcds_scale_lane #(
    .ADC_BITS (ADC_BITS), .MUL (MUL_POT), .DIV13 (1'b1), .OUT_W (POT_W)
  ) u_pot (
    .clk (clk), .rst (rst), .sample (is_sample),
    .raw (raw_pot), .value_next (word_next.pot_mv)
  );

  mcds_scale_lane #(
    .ADC_BITS (ADC_BITS), .MUL (MUL_POT), .DIV13 (1'b1), .OUT_W (POT_W)
  ) u_up (
    .clk (clk), .rst (rst), .sample (is_sample),
    .raw (raw_up_sw), .value_next (word_next.up_sw_mv)
  );

  mcds_scale_lane #(
    .ADC_BITS (ADC_BITS), .MUL (MUL_POT), .DIV13 (1'b1), .OUT_W (POT_W)
  ) u_down (
    .clk (clk), .rst (rst), .sample (is_sample),
    .raw (raw_down_sw), .value_next (word_next.down_sw_mv)
  );

  // Merge lanes into the output stage
  mcds_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_word  (word_next),
    .push_ready (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word)
  );

  assign states       = out_word.states;
  assign change_flags = out_word.change_flags;
  assign battery_mv   = out_word.battery_mv;
  assign coil_mv      = out_word.coil_mv;
  assign coil_ma      = out_word.coil_ma;
  assign pot_mv       = out_word.pot_mv;
  assign up_sw_mv     = out_word.up_sw_mv;
  assign down_sw_mv   = out_word.down_sw_mv;

endmodule

// ----- rtl/core/mcds_checker.sv -----
// Port-level checks for the debounce and scaler top level, bound to it.
// Depends on mcds_pkg and multi_channel_input_debounce_scaler.
`timescale 1ns / 1ps

module mcds_checker
  import mcds_pkg::*;
(
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic           req_type,
  input logic [NCH-1:0] clear_mask,
  input logic           out_valid,
  input logic           out_ready,
  input logic [NCH-1:0] change_flags
);

  // Hold a stalled word
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(change_flags))
    else $error("stalled result word changed or dropped");

  // Reset empties the output stage
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word valid after reset");

  // Input back-pressure only follows an output stall
  assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("input blocked without output stall");

  // A full-mask clear shows all flags dropped in its own result word
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && req_type && (clear_mask == '1) &&
    (!out_valid || out_ready) |=> out_valid && (change_flags == '0))
    else $error("change flags survived a full clear");

endmodule

bind multi_channel_input_debounce_scaler mcds_checker u_mcds_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .req_type     (req_type),
  .clear_mask   (clear_mask),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .change_flags (change_flags)
);

// ----- sim/multi_channel_input_debounce_scaler_test.sv -----
// Testbench for the six-channel input debouncer and ADC scaler block.
// Depends on mcds_pkg and multi_channel_input_debounce_scaler; predicts each result word
// from a local model of the debounce timers, states, flags and held scaled values.
`timescale 1ns / 1ps

module multi_channel_input_debounce_scaler_test;
  import mcds_pkg::*;

  localparam int ADC_BITS    = 10;
  localparam int CYCLE_LIMIT = 400000;

  typedef logic [NCH-1:0][ADC_BITS-1:0] adc_codes_t;

  typedef struct packed {
    logic [NCH-1:0]              active;
    logic [1:0]                  analog;
    logic [NCH-1:0][TIMER_W-1:0] limit;
  } ch_config_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                req_type = REQ_SAMPLE;
  logic [NCH-1:0]      pin_levels = '0;
  logic [NCH-1:0]      clear_mask = '0;
  logic [ADC_BITS-1:0] raw_battery = '0;
  logic [ADC_BITS-1:0] raw_coil_volt = '0;
  logic [ADC_BITS-1:0] raw_coil_curr = '0;
  logic [ADC_BITS-1:0] raw_pot = '0;
  logic [ADC_BITS-1:0] raw_up_sw = '0;
  logic [ADC_BITS-1:0] raw_down_sw = '0;

  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [NCH-1:0]      states;
  logic [NCH-1:0]      change_flags;
  logic [BATT_W-1:0]   battery_mv;
  logic [COILV_W-1:0]  coil_mv;
  logic [COILI_W-1:0]  coil_ma;
  logic [POT_W-1:0]    pot_mv;
  logic [POT_W-1:0]    up_sw_mv;
  logic [POT_W-1:0]    down_sw_mv;

  // Local copy of the block's state and settings
  ch_config_t         live_cfg;
  logic [TIMER_W-1:0] deb_timer [NCH];
  logic [NCH-1:0]     deb_state;
  logic [NCH-1:0]     deb_flags;
  logic [15:0]        scaled_hold [NCH];

  result_t pending_results [$];
  int      error_count = 0;
  int      cycle_count = 0;
  int      burst_left = 0;
  bit      sending = 1'b0;

  logic [15:0] ready_pattern = 16'hFFFF;
  int          pattern_age = 0;

  multi_channel_input_debounce_scaler #(
    .ADC_BITS(ADC_BITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .pin_levels(pin_levels),
    .clear_mask(clear_mask),
    .raw_battery(raw_battery),
    .raw_coil_volt(raw_coil_volt),
    .raw_coil_curr(raw_coil_curr),
    .raw_pot(raw_pot),
    .raw_up_sw(raw_up_sw),
    .raw_down_sw(raw_down_sw),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .states(states),
    .change_flags(change_flags),
    .battery_mv(battery_mv),
    .coil_mv(coil_mv),
    .coil_ma(coil_ma),
    .pot_mv(pot_mv),
    .up_sw_mv(up_sw_mv),
    .down_sw_mv(down_sw_mv)
  );

  always #5 clk = ~clk;

  // End the run if the traffic hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Stall the result side on a rotating pattern, reloaded now and then
  always @(posedge clk) begin
    if (pattern_age == 0) begin
      pattern_age <= $urandom_range(16, 64);
      case ($urandom_range(0, 3))
        0: ready_pattern <= 16'hFFFF;
        1: ready_pattern <= 16'($urandom) & 16'($urandom) | 16'h0001;
        default: ready_pattern <= 16'($urandom);
      endcase
    end else begin
      pattern_age <= pattern_age - 1;
      ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
    end
    out_ready <= ready_pattern[0];
  end

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      error_count++;
    end
  endtask

  // Compare each result word with the oldest expected word
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("states", 32'(want.states), 32'(states));
        check_field("change_flags", 32'(want.change_flags), 32'(change_flags));
        check_field("battery_mv", 32'(want.battery_mv), 32'(battery_mv));
        check_field("coil_mv", 32'(want.coil_mv), 32'(coil_mv));
        check_field("coil_ma", 32'(want.coil_ma), 32'(coil_ma));
        check_field("pot_mv", 32'(want.pot_mv), 32'(pot_mv));
        check_field("up_sw_mv", 32'(want.up_sw_mv), 32'(up_sw_mv));
        check_field("down_sw_mv", 32'(want.down_sw_mv), 32'(down_sw_mv));
      end
    end
  end

  // Advance the local debouncer and scaler by one word and queue its result
  task automatic debounce_and_scale(input req_type_t kind, input logic [NCH-1:0] pins,
                                    input logic [NCH-1:0] clr, input adc_codes_t codes);
    result_t        r;
    int unsigned    code;
    logic           want;
    logic [NCH-1:0] skip;
    if (kind == REQ_CLEAR) begin
      deb_flags = deb_flags & ~clr;
    end else begin
      for (int ch = 0; ch < NCH; ch++) begin
        code = 32'(codes[ch]);
        if (ch < 2)
          scaled_hold[ch] = 16'(code * MUL_VOLT);
        else if (ch == 2)
          scaled_hold[ch] = 16'(code * MUL_CURR);
        else
          scaled_hold[ch] = 16'((code * MUL_POT) / 13);
      end
      skip = '0;
      skip[UP_BIT] = live_cfg.analog[0];
      skip[DOWN_BIT] = live_cfg.analog[1];
      for (int ch = 0; ch < NCH; ch++) begin
        if (!skip[ch]) begin
          want = (pins[ch] == live_cfg.active[ch]);
          if (want == deb_state[ch]) begin
            deb_timer[ch] = '0;
          end else if (deb_timer[ch] >= live_cfg.limit[ch]) begin
            deb_state[ch] = ~deb_state[ch];
            deb_flags[ch] = 1'b1;
            deb_timer[ch] = '0;
          end else begin
            deb_timer[ch] = deb_timer[ch] + 1'b1;
          end
        end
      end
    end
    r.states = deb_state;
    r.change_flags = deb_flags;
    r.battery_mv = scaled_hold[0][BATT_W-1:0];
    r.coil_mv = scaled_hold[1][COILV_W-1:0];
    r.coil_ma = scaled_hold[2][COILI_W-1:0];
    r.pot_mv = scaled_hold[3][POT_W-1:0];
    r.up_sw_mv = scaled_hold[4][POT_W-1:0];
    r.down_sw_mv = scaled_hold[5][POT_W-1:0];
    pending_results.push_back(r);
  endtask

  // Offer one word, hold it until accepted, then idle between bursts
  task automatic send_word(input req_type_t kind, input logic [NCH-1:0] pins,
                           input logic [NCH-1:0] clr, input adc_codes_t codes);
    in_valid <= 1'b1;
    sending = 1'b1;
    req_type <= kind;
    pin_levels <= pins;
    clear_mask <= clr;
    raw_battery <= codes[0];
    raw_coil_volt <= codes[1];
    raw_coil_curr <= codes[2];
    raw_pot <= codes[3];
    raw_up_sw <= codes[4];
    raw_down_sw <= codes[5];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    debounce_and_scale(kind, pins, clr, codes);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      sending = 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(0, 8);
    end
  endtask

  // Drop valid and wait until every expected word is back
  task automatic drain();
    if (sending) begin
      in_valid <= 1'b0;
      sending = 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
  endtask

  task automatic read_reg(input reg_idx_t idx, output logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    value = prdata;
  endtask

  task automatic bus_release();
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] reg_value(input ch_config_t c, input reg_idx_t idx);
    case (idx)
      REG_ACTIVE_LEVELS: return 32'(c.active);
      REG_ANALOG_MODE:   return 32'(c.analog);
      default:           return 32'(c.limit[idx - REG_LIMIT_DIMM]);
    endcase
  endfunction

  // Write every register once the block has gone idle
  task automatic program_config(input ch_config_t c);
    drain();
    for (int i = REG_ACTIVE_LEVELS; i <= REG_LIMIT_DOWN; i++)
      write_reg(reg_idx_t'(i), reg_value(c, reg_idx_t'(i)));
    bus_release();
    live_cfg = c;
  endtask

  task automatic check_registers(input ch_config_t c);
    logic [31:0] got;
    for (int i = REG_ACTIVE_LEVELS; i <= REG_LIMIT_DOWN; i++) begin
      read_reg(reg_idx_t'(i), got);
      if (got !== reg_value(c, reg_idx_t'(i))) begin
        $error("register %0d readback: expected %0d, got %0d", i,
               reg_value(c, reg_idx_t'(i)), got);
        error_count++;
      end
    end
    bus_release();
  endtask

  function automatic adc_codes_t fill_codes(input logic [ADC_BITS-1:0] v);
    adc_codes_t c;
    for (int i = 0; i < NCH; i++) c[i] = v;
    return c;
  endfunction

  // Mostly full-range codes, with the two extremes mixed in
  function automatic adc_codes_t random_codes();
    adc_codes_t c;
    for (int i = 0; i < NCH; i++) begin
      case ($urandom_range(0, 7))
        0:       c[i] = '0;
        1:       c[i] = '1;
        default: c[i] = ADC_BITS'($urandom_range(0, (1 << ADC_BITS) - 1));
      endcase
    end
    return c;
  endfunction

  // Hold pin levels for random runs so timers reach their limits, with glitches
  // and clear requests sprinkled in
  task automatic run_traffic(input int words, input int hold_max);
    logic [NCH-1:0] held;
    int             run;
    held = 6'($urandom_range(0, 63));
    run = $urandom_range(1, hold_max);
    repeat (words) begin
      case ($urandom_range(0, 19))
        0, 1: send_word(REQ_CLEAR, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                        random_codes());
        2: send_word(REQ_SAMPLE, held ^ 6'($urandom_range(1, 63)),
                     6'($urandom_range(0, 63)), random_codes());
        default: send_word(REQ_SAMPLE, held, 6'($urandom_range(0, 63)), random_codes());
      endcase
      if (run == 0) begin
        held = held ^ 6'($urandom_range(1, 63));
        run = $urandom_range(1, hold_max);
      end else begin
        run--;
      end
    end
  endtask

  task automatic test_register_access();
    ch_config_t c;
    c.active = '0;
    c.analog = '0;
    c.limit = {NCH{LIMIT_RESET}};
    check_registers(c);
    c.active = 6'($urandom_range(0, 63));
    c.analog = 2'($urandom_range(0, 3));
    for (int i = 0; i < NCH; i++) c.limit[i] = 8'($urandom_range(0, 255));
    program_config(c);
    check_registers(c);
  endtask

  task automatic test_directed_words();
    ch_config_t     c;
    logic [NCH-1:0] against;
    // Limit zero: every disagreeing level is taken at once
    c.active = '0;
    c.analog = '0;
    c.limit = '0;
    program_config(c);
    send_word(REQ_SAMPLE, '0, '0, fill_codes('0));
    send_word(REQ_SAMPLE, '1, '1, fill_codes('1));
    // Clear requests ignore pins and codes and repeat the held scaled values
    send_word(REQ_CLEAR, '1, 6'h15, fill_codes(10'h2AA));
    send_word(REQ_CLEAR, '0, '0, fill_codes(10'h155));
    send_word(REQ_CLEAR, 6'h15, 6'h2A, fill_codes('1));
    send_word(REQ_SAMPLE, 6'h2A, 6'h15, fill_codes(10'h2AA));
    send_word(REQ_SAMPLE, 6'h15, 6'h2A, fill_codes(10'h155));
    send_word(REQ_CLEAR, '0, '1, fill_codes('0));
    // Analog up and down channels hold timer, state and flag
    c.analog = 2'b11;
    c.active = '1;
    program_config(c);
    send_word(REQ_SAMPLE, '0, '0, random_codes());
    send_word(REQ_SAMPLE, '1, '0, random_codes());
    // Short limit: an agreeing tick restarts the count, the next run flips
    c.analog = '0;
    c.limit = {NCH{8'd3}};
    program_config(c);
    against = c.active ^ deb_state;
    repeat (3) send_word(REQ_SAMPLE, against, '0, random_codes());
    send_word(REQ_SAMPLE, ~against, '0, random_codes());
    repeat (4) send_word(REQ_SAMPLE, against, '0, random_codes());
  endtask

  // Longest limit: the flip lands on the 256th disagreeing tick
  task automatic test_limit_extremes();
    ch_config_t c;
    c.active = 6'($urandom_range(0, 63));
    c.analog = '0;
    c.limit = {NCH{8'hFF}};
    program_config(c);
    repeat (257) send_word(REQ_SAMPLE, c.active ^ deb_state, 6'($urandom_range(0, 63)),
                           random_codes());
  endtask

  task automatic test_random_traffic();
    ch_config_t c;
    c.active = '0;
    c.analog = '0;
    c.limit = {NCH{LIMIT_RESET}};
    program_config(c);
    run_traffic(300, 30);

    c.active = '1;
    c.analog = 2'b11;
    c.limit = '0;
    program_config(c);
    run_traffic(300, 4);

    c.active = 6'($urandom_range(0, 63));
    c.analog = 2'b01;
    for (int i = 0; i < NCH; i++) c.limit[i] = 8'($urandom_range(0, 15));
    program_config(c);
    run_traffic(300, 40);

    c.active = 6'($urandom_range(0, 63));
    c.analog = 2'b10;
    for (int i = 0; i < NCH; i++) c.limit[i] = (i < 2) ? 8'hFF : 8'($urandom_range(0, 7));
    program_config(c);
    run_traffic(300, 300);

    c.active = 6'($urandom_range(0, 63));
    c.analog = 2'($urandom_range(0, 3));
    for (int i = 0; i < NCH; i++) c.limit[i] = 8'($urandom_range(0, 31));
    program_config(c);
    run_traffic(300, 60);
  endtask

  initial begin
    live_cfg.active = '0;
    live_cfg.analog = '0;
    live_cfg.limit = {NCH{LIMIT_RESET}};
    deb_state = '0;
    deb_flags = '0;
    for (int i = 0; i < NCH; i++) begin
      deb_timer[i] = '0;
      scaled_hold[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_register_access();
    test_directed_words();
    test_limit_extremes();
    test_random_traffic();

    // Let the last words settle, then report
    drain();
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- multi_channel_input_debounce_scaler.f -----
rtl/core/mcds_pkg.sv
rtl/core/mcds_deb_lane.sv
rtl/core/mcds_scale_lane.sv
rtl/core/mcds_merge.sv
rtl/core/multi_channel_input_debounce_scaler.sv
rtl/core/mcds_checker.sv
sim/multi_channel_input_debounce_scaler_test.sv
